// ===== src/sram_pkg.sv =====
// sram_pkg: shared types and codes for the sensor running average monitor
// no dependencies
`default_nettype none
package sram_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    AL_NONE = 2'd0,
    AL_HIGH = 2'd1,
    AL_LOW  = 2'd2
  } alarm_t;

  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_READING  = 1'b1;

  localparam logic [0:0] REG_MAX_TEMP = 1'b0;
  localparam logic [0:0] REG_MIN_TEMP = 1'b1;

  localparam logic signed [15:0] MAX_TEMP_RESET = 16'sd5120;
  localparam logic signed [15:0] MIN_TEMP_RESET = 16'sd2560;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_CALC  = 2'd2,
    S_OUT   = 2'd3
  } fsm_t;

  // request word travelling along the row of cells
  typedef struct packed {
    logic        valid;
    logic        op;
    logic [15:0] probe_id;
    logic [15:0] room_id;
    logic signed [15:0] reading;
    logic [31:0] timestamp;
    logic        hit;
  } req_t;

endpackage
`default_nettype wire

// ===== src/sram_cell.sv =====
// sram_cell: one sensor table entry with its reading window
// depends on sram_pkg; the request word passes to the next cell each cycle
`default_nettype none
module sram_cell #(
  parameter int WINDOW_LENGTH = 5,
  parameter int SUM_W = 20,
  parameter int FILL_W = 3
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   clear,
  input  wire logic                   alloc,
  input  wire logic [15:0]            new_id,
  input  wire logic [15:0]            new_room,
  input  wire sram_pkg::req_t         req_in,
  output sram_pkg::req_t              req_out,
  output logic                        hit_now,
  output logic [15:0]                 room_o,
  output logic [31:0]                 time_o,
  output logic signed [SUM_W-1:0]     sum_o,
  output logic                        full_o
);
  import sram_pkg::*;

  logic                    used_r;
  logic [15:0]             id_r;
  logic [15:0]             room_r;
  logic [31:0]             time_r;
  logic [FILL_W-1:0]       fill_r;
  logic signed [15:0]      win_r [WINDOW_LENGTH];
  logic signed [SUM_W-1:0] sum_r;
  req_t                    req_r;
  req_t                    req_nxt;
  logic                    take;

  assign hit_now = req_in.valid && !req_in.hit && req_in.op == OP_READING && used_r &&
                   id_r == req_in.probe_id;
  assign take = hit_now;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      used_r <= 1'b0;
    end else if (alloc) begin
      used_r <= 1'b1;
    end
  end

  always_comb begin
    req_nxt     = req_in;
    req_nxt.hit = req_in.hit | hit_now;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r.valid <= 1'b0;
    end else begin
      req_r <= req_nxt;
    end
  end
  assign req_out = req_r;

  always_ff @(posedge clk) begin
    if (alloc) begin
      id_r   <= new_id;
      room_r <= new_room;
      time_r <= '0;
      fill_r <= '0;
      sum_r  <= '0;
    end else if (take) begin
      time_r <= req_in.timestamp;
      if (fill_r != FILL_W'(WINDOW_LENGTH)) fill_r <= fill_r + 1'b1;
      // running sum: add newest, drop oldest once window full
      if (fill_r == FILL_W'(WINDOW_LENGTH))
        sum_r <= sum_r + SUM_W'(req_in.reading) - SUM_W'(win_r[0]);
      else
        sum_r <= sum_r + SUM_W'(req_in.reading);
      for (int k = 0; k < WINDOW_LENGTH - 1; k++) win_r[k] <= win_r[k+1];
      win_r[WINDOW_LENGTH-1] <= req_in.reading;
    end
  end

  assign room_o = room_r;
  assign time_o = time_r;
  assign sum_o  = sum_r;
  assign full_o = fill_r == FILL_W'(WINDOW_LENGTH);
endmodule
`default_nettype wire

// ===== src/sram_avg.sv =====
// sram_avg: window average and threshold alarm, one register stage
// depends on sram_pkg
`default_nettype none
module sram_avg #(
  parameter int WINDOW_LENGTH = 5,
  parameter int SUM_W = 20
) (
  input  wire logic                   clk,
  input  wire logic signed [SUM_W-1:0] sum_i,
  input  wire logic                   full_i,
  input  wire logic signed [15:0]     max_t,
  input  wire logic signed [15:0]     min_t,
  output logic signed [15:0]          avg_o,
  output sram_pkg::alarm_t            alarm_o
);
  import sram_pkg::*;

  localparam int SHIFT  = SUM_W + 4;
  localparam int PROD_W = SUM_W + SHIFT + 1;
  localparam logic [SHIFT:0] RECIP =
    (SHIFT+1)'(((64'd1 << SHIFT) + 64'(WINDOW_LENGTH - 1)) / 64'(WINDOW_LENGTH));

  logic [SUM_W-1:0]        mag;
  logic [PROD_W-1:0]       prod;
  logic [SUM_W-1:0]        quo;
  logic signed [SUM_W-1:0] q;
  logic signed [15:0]      avg_r;

  // magnitude times rounded-up reciprocal, sign restored: truncates toward zero
  assign mag  = sum_i[SUM_W-1] ? $unsigned(-sum_i) : $unsigned(sum_i);
  assign prod = PROD_W'(mag) * PROD_W'(RECIP);
  assign quo  = prod[SHIFT +: SUM_W];
  assign q    = !full_i ? '0 : (sum_i[SUM_W-1] ? -$signed(quo) : $signed(quo));

  always_ff @(posedge clk) begin
    avg_r <= q[15:0];
  end

  assign avg_o = avg_r;
  always_comb begin
    if (avg_r > max_t)      alarm_o = AL_HIGH;
    else if (avg_r < min_t) alarm_o = AL_LOW;
    else                    alarm_o = AL_NONE;
  end
endmodule
`default_nettype wire

// ===== src/sensor_running_average_monitor.sv =====
// sensor_running_average_monitor: sensor table as a row of cells with averaging
// depends on sram_pkg, sram_cell, sram_avg
//
//  channel | direction | handshake
//  in_     | input     | in_valid / in_stall
//  out_    | output    | out_valid / out_stall
//  cfg_    | input     | apb write/read, pready always high
//
// from acceptance to the next acceptance a register word passes through the output
// state only, while a reading word first walks the row of cells one cell per cycle,
// then the average is taken and the result is registered before the output state.
// one word in flight at a time; the result waits in the output register while stalled.
// synchronous active-low reset empties the table and restores the thresholds.
`default_nettype none
module sensor_running_average_monitor #(
  parameter int MAX_SENSORS = 16,
  parameter int WINDOW_LENGTH = 5
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic         in_op,
  input  wire logic [15:0]  in_probe_id,
  input  wire logic [15:0]  in_room_id_in,
  input  wire logic signed [15:0] in_reading,
  input  wire logic [31:0]  in_timestamp_in,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [1:0]        out_status,
  output logic [15:0]       out_room_id_out,
  output logic signed [15:0] out_average,
  output logic [1:0]        out_alarm,
  output logic [31:0]       out_last_timestamp,
  output logic              out_window_full,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:2]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import sram_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SENSORS + 1);
  localparam int IDX_W  = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int FILL_W = $clog2(WINDOW_LENGTH + 1);
  localparam int SUM_W  = 16 + $clog2(WINDOW_LENGTH + 1);
  localparam int STEP_W = $clog2(MAX_SENSORS + 2);

  logic signed [15:0] max_r, min_r;
  logic [CNT_W-1:0]   count_r;
  fsm_t               state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  req_t               head;
  req_t               chain [MAX_SENSORS+1];
  logic [MAX_SENSORS-1:0] hit_v;
  logic [15:0]        room_a [MAX_SENSORS];
  logic [31:0]        time_a [MAX_SENSORS];
  logic signed [SUM_W-1:0] sum_a [MAX_SENSORS];
  logic [MAX_SENSORS-1:0] full_a;
  logic [IDX_W-1:0]   idx_r;
  logic               found_r;
  logic               hit_any;
  logic [IDX_W-1:0]   hit_idx;
  logic signed [SUM_W-1:0] sum_sel;
  logic               full_sel;
  logic signed [15:0] avg;
  alarm_t             alarm;
  logic               acc, tbl_full, do_alloc;
  logic [1:0]         status_r;
  logic [15:0]        room_o_r;
  logic [31:0]        time_o_r;
  logic               full_o_r;
  logic               avg_ok_r;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_TEMP_RESET;
      min_r <= MIN_TEMP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2] == REG_MAX_TEMP) max_r <= cfg_pwdata[15:0];
      else                              min_r <= cfg_pwdata[15:0];
    end
  end
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_TEMP) ? {{16{max_r[15]}}, max_r}
                                                     : {{16{min_r[15]}}, min_r};

  assign in_stall = state_r != S_IDLE;
  assign acc      = in_valid && !in_stall;
  assign tbl_full = count_r == CNT_W'(MAX_SENSORS);
  assign do_alloc = acc && in_op == OP_REGISTER && !tbl_full;

  always_comb begin
    head.valid     = acc && in_op == OP_READING;
    head.op        = in_op;
    head.probe_id  = in_probe_id;
    head.room_id   = in_room_id_in;
    head.reading   = in_reading;
    head.timestamp = in_timestamp_in;
    head.hit       = 1'b0;
  end

  assign chain[0] = head;
  for (genvar g = 0; g < MAX_SENSORS; g++) begin : g_cell
    sram_cell #(.WINDOW_LENGTH(WINDOW_LENGTH), .SUM_W(SUM_W), .FILL_W(FILL_W)) u_cell (
      .clk, .rst_n, .clear(1'b0),
      .alloc(do_alloc && count_r[IDX_W-1:0] == IDX_W'(g) && !tbl_full),
      .new_id(in_probe_id), .new_room(in_room_id_in),
      .req_in(g == 0 ? head : chain[g]),
      .req_out(chain[g+1]),
      .hit_now(hit_v[g]),
      .room_o(room_a[g]), .time_o(time_a[g]), .sum_o(sum_a[g]), .full_o(full_a[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else if (do_alloc) count_r <= count_r + 1'b1;
  end

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int k = MAX_SENSORS - 1; k >= 0; k--) begin
      if (hit_v[k]) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(k);
      end
    end
  end

  // record which cell claimed the walking word
  always_ff @(posedge clk) begin
    if (acc) found_r <= hit_any;
    else if (hit_any) found_r <= 1'b1;
    if (hit_any) idx_r <= hit_idx;
  end

  assign sum_sel  = sum_a[idx_r];
  assign full_sel = full_a[idx_r];

  sram_avg #(.WINDOW_LENGTH(WINDOW_LENGTH), .SUM_W(SUM_W)) u_avg (
    .clk, .sum_i(sum_sel), .full_i(full_sel), .max_t(max_r), .min_t(min_r),
    .avg_o(avg), .alarm_o(alarm)
  );

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_IDLE: begin
        step_nxt = '0;
        if (acc) state_nxt = (in_op == OP_READING) ? S_SCAN : S_OUT;
      end
      S_SCAN: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(MAX_SENSORS)) state_nxt = S_CALC;
      end
      S_CALC: state_nxt = S_OUT;
      S_OUT:  if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_op == OP_REGISTER) begin
      status_r <= tbl_full ? ST_FULL : ST_OK;
      room_o_r <= tbl_full ? 16'd0 : in_room_id_in;
      time_o_r <= '0;
      full_o_r <= 1'b0;
      avg_ok_r <= 1'b0;
    end else if (state_r == S_CALC) begin
      status_r <= found_r ? ST_OK : ST_UNKNOWN;
      room_o_r <= found_r ? room_a[idx_r] : 16'd0;
      time_o_r <= found_r ? time_a[idx_r] : 32'd0;
      full_o_r <= found_r && full_sel;
      avg_ok_r <= found_r;
    end
  end

  always_comb begin
    out_valid = state_r == S_OUT;
  end
  assign out_status         = status_r;
  assign out_room_id_out    = room_o_r;
  assign out_last_timestamp = time_o_r;
  assign out_window_full    = full_o_r;
  assign out_average        = avg_ok_r ? avg : 16'sd0;
  assign out_alarm          = avg_ok_r ? alarm : AL_NONE;
endmodule
`default_nettype wire
